### sv/icw_pkg.sv
package icw_pkg;

	localparam int DELAY_W = 16;
	localparam int COUNT_W = 3;
	localparam int IDLE_CHECKS_DEF = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [DELAY_W-1:0] CHECK_DELAY_RST = 16'd100;

	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_ACTIVITY = 2'd1;
	localparam logic [1:0] CMD_RESTART  = 2'd2;
	localparam logic [1:0] CMD_NO_DELAY = 2'd3;

	localparam logic REG_CHECK_DELAY     = 1'b0;
	localparam logic REG_SOURCES_TRACKED = 1'b1;

	typedef struct packed {
		logic [1:0] command;
		logic       all_idle;
	} icw_item_t;

	typedef struct packed {
		logic idle_started;
		logic modified_seen;
		logic counting;
	} icw_result_t;

	typedef struct packed {
		logic [DELAY_W-1:0] check_delay;
		logic               sources_tracked;
	} icw_cfg_t;

endpackage

### sv/idle_confirmation_watcher_core.sv
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    icw_item_t (command, all_idle)
// result    out        result_valid / result_stall icw_result_t (idle_started,
//                                                  modified_seen, counting)
// config    in         APB psel/penable/pwrite    check_delay, sources_tracked
//
// One item per cycle unless the result stalls; item_s1 then result_q hold it.
// The item register feeds the timer update and the result register in one pass.
// arst_n clears timers, count, flags and valid flags; config resets to defaults.
// A stalled result holds; the item stage holds behind it and stalls the input.
module idle_confirmation_watcher_core #(
	parameter int IDLE_CHECKS = icw_pkg::IDLE_CHECKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  icw_pkg::icw_item_t          item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output icw_pkg::icw_result_t        result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [icw_pkg::ADDR_W-1:0]  paddr,
	input  logic [icw_pkg::DATA_W-1:0]  pwdata,
	output logic [icw_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	icw_pkg::icw_cfg_t    cfg;
	icw_pkg::icw_item_t   item_s1;
	logic                 valid_s1;
	icw_pkg::icw_result_t res_d;
	icw_pkg::icw_result_t result_q;
	logic                 result_valid_q;
	logic                 out_free;
	logic                 adv;
	logic                 take;

	assign out_free   = !result_valid_q || !result_stall;
	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign take       = item_valid && !item_stall;

	icw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	icw_engine #(
		.IDLE_CHECKS (IDLE_CHECKS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### sv/icw_cfg.sv
module icw_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [icw_pkg::ADDR_W-1:0]    paddr,
	input  logic [icw_pkg::DATA_W-1:0]    pwdata,
	output logic [icw_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output icw_pkg::icw_cfg_t             cfg
);

	logic [icw_pkg::DELAY_W-1:0] check_delay_q;
	logic                        sources_tracked_q;
	logic                        wr_en;
	logic                        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_delay_q     <= icw_pkg::CHECK_DELAY_RST;
			sources_tracked_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				icw_pkg::REG_CHECK_DELAY: begin
					check_delay_q <= pwdata[icw_pkg::DELAY_W-1:0];
				end
				icw_pkg::REG_SOURCES_TRACKED: begin
					sources_tracked_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			icw_pkg::REG_CHECK_DELAY: begin
				prdata[icw_pkg::DELAY_W-1:0] = check_delay_q;
			end
			icw_pkg::REG_SOURCES_TRACKED: begin
				prdata[0] = sources_tracked_q;
			end
			default: begin
			end
		endcase
	end

	assign cfg.check_delay     = check_delay_q;
	assign cfg.sources_tracked = sources_tracked_q;

endmodule

### sv/icw_engine.sv
module icw_engine #(
	parameter int IDLE_CHECKS = icw_pkg::IDLE_CHECKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  icw_pkg::icw_item_t    item,
	input  icw_pkg::icw_cfg_t     cfg,
	output icw_pkg::icw_result_t  result
);

	localparam logic [icw_pkg::COUNT_W-1:0] LIMIT = icw_pkg::COUNT_W'(IDLE_CHECKS);

	logic                        post_act_q, post_act_d;
	logic [icw_pkg::DELAY_W-1:0] post_left_q, post_left_d;
	logic                        chk_act_q, chk_act_d;
	logic [icw_pkg::DELAY_W-1:0] chk_left_q, chk_left_d;
	logic [icw_pkg::COUNT_W-1:0] chk_cnt_q, chk_cnt_d;
	logic                        no_delay_q, no_delay_d;
	logic [icw_pkg::DELAY_W-1:0] load_val;
	logic                        started;
	logic                        modified;

	assign load_val = (cfg.check_delay == '0) ? icw_pkg::DELAY_W'(1) : cfg.check_delay;

	always_comb begin
		logic post_exp;
		logic chk_exp;
		post_act_d  = post_act_q;
		post_left_d = post_left_q;
		chk_act_d   = chk_act_q;
		chk_left_d  = chk_left_q;
		chk_cnt_d   = chk_cnt_q;
		no_delay_d  = no_delay_q;
		started     = 1'b0;
		modified    = 1'b0;
		post_exp    = post_act_q && (post_left_q <= icw_pkg::DELAY_W'(1));
		chk_exp     = chk_act_q && (chk_left_q <= icw_pkg::DELAY_W'(1));
		unique case (item.command)
			icw_pkg::CMD_TICK: begin
				if (post_act_q && !post_exp) begin
					post_left_d = post_left_q - icw_pkg::DELAY_W'(1);
				end
				if (chk_act_q && !chk_exp) begin
					chk_left_d = chk_left_q - icw_pkg::DELAY_W'(1);
				end
				if (post_exp) begin
					post_act_d  = 1'b0;
					post_left_d = '0;
					chk_cnt_d   = '0;
					no_delay_d  = 1'b0;
					chk_act_d   = 1'b1;
					chk_left_d  = load_val;
				end
				if (chk_exp) begin
					if (item.all_idle) begin
						if (no_delay_d || chk_cnt_d >= LIMIT) begin
							chk_act_d  = 1'b0;
							chk_left_d = '0;
							chk_cnt_d  = '0;
							no_delay_d = 1'b0;
							started    = cfg.sources_tracked;
						end else begin
							chk_cnt_d  = chk_cnt_d + icw_pkg::COUNT_W'(1);
							chk_act_d  = 1'b1;
							chk_left_d = load_val;
						end
					end else if (!no_delay_d) begin
						chk_act_d   = 1'b0;
						chk_left_d  = '0;
						chk_cnt_d   = '0;
						no_delay_d  = 1'b0;
						post_act_d  = 1'b1;
						post_left_d = load_val;
					end else begin
						chk_act_d  = 1'b1;
						chk_left_d = load_val;
					end
				end
			end
			icw_pkg::CMD_ACTIVITY: begin
				if (!no_delay_q) begin
					chk_act_d   = 1'b0;
					chk_left_d  = '0;
					chk_cnt_d   = '0;
					no_delay_d  = 1'b0;
					post_act_d  = 1'b1;
					post_left_d = load_val;
				end
				modified = 1'b1;
			end
			icw_pkg::CMD_RESTART: begin
				chk_act_d   = 1'b0;
				chk_left_d  = '0;
				chk_cnt_d   = '0;
				no_delay_d  = 1'b0;
				post_act_d  = 1'b1;
				post_left_d = load_val;
			end
			icw_pkg::CMD_NO_DELAY: begin
				chk_cnt_d  = '0;
				no_delay_d = 1'b1;
				chk_act_d  = 1'b1;
				chk_left_d = load_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_act_q  <= 1'b0;
			post_left_q <= '0;
			chk_act_q   <= 1'b0;
			chk_left_q  <= '0;
			chk_cnt_q   <= '0;
			no_delay_q  <= 1'b0;
		end else if (step) begin
			post_act_q  <= post_act_d;
			post_left_q <= post_left_d;
			chk_act_q   <= chk_act_d;
			chk_left_q  <= chk_left_d;
			chk_cnt_q   <= chk_cnt_d;
			no_delay_q  <= no_delay_d;
		end
	end

	assign result.idle_started  = started;
	assign result.modified_seen = modified;
	assign result.counting      = chk_act_d;

endmodule
